FILE: hdl/mme_pkg.sv
// Shared types, sizes and a helper function of the matrix multiply engine.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int DIM_W  = 4;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(2 * DEPTH + 1);
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = PROD_W + IDX_W;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ROWS_M  = 2'd0;
  localparam logic [1:0] REG_INNER_K = 2'd1;
  localparam logic [1:0] REG_COLS_N  = 2'd2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // Effective dimensions, already clamped to 1..MAX_DIM.
  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] k;
    logic [DIM_W-1:0] n;
  } mme_dims_t;

  // Tag that travels with one store read through the MAC pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mme_issue_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] v;
    if (r == '0) begin
      v = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      v = DIM_W'(MAX_DIM);
    end else begin
      v = r;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mme_if.sv
// Valid/ready stream interfaces for the element input and the result output.
// Depends on mme_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

interface mme_in_if;
  logic                 valid;
  logic                 ready;
  mme_pkg::data_t       element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface mme_out_if;
  logic                       valid;
  logic                       ready;
  mme_pkg::data_t             product_element;
  logic [mme_pkg::IDX_W-1:0]  row_index;
  logic [mme_pkg::IDX_W-1:0]  col_index;
  logic                       last_of_matrix;

  modport source (output valid, output product_element, output row_index,
                  output col_index, output last_of_matrix, input ready);
  modport sink   (input valid, input product_element, input row_index,
                  input col_index, input last_of_matrix, output ready);
endinterface

`default_nettype wire

FILE: hdl/mme_regs.sv
// APB-style dimension registers and their clamped effective values.
// Depends on mme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mme_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mme_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mme_pkg::PDATA_W-1:0] pwdata,
  output logic      [mme_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output mme_pkg::mme_dims_t               dims
);
  import mme_pkg::*;

  logic [DIM_W-1:0] rows_m_r, inner_k_r, cols_n_r;
  logic [1:0]       reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r  <= DIM_W'(1);
      inner_k_r <= DIM_W'(1);
      cols_n_r  <= DIM_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROWS_M:  rows_m_r  <= pwdata[DIM_W-1:0];
        REG_INNER_K: inner_k_r <= pwdata[DIM_W-1:0];
        REG_COLS_N:  cols_n_r  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS_M:  prdata = {{(PDATA_W-DIM_W){1'b0}}, rows_m_r};
      REG_INNER_K: prdata = {{(PDATA_W-DIM_W){1'b0}}, inner_k_r};
      REG_COLS_N:  prdata = {{(PDATA_W-DIM_W){1'b0}}, cols_n_r};
      default:     prdata = '0;
    endcase
  end

  assign dims.m = eff_dim(rows_m_r);
  assign dims.k = eff_dim(inner_k_r);
  assign dims.n = eff_dim(cols_n_r);

endmodule

`default_nettype wire

FILE: hdl/mme_mem.sv
// Operand stores for A and B: one write port and one registered read port each.
// Depends on mme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mme_mem (
  input  wire logic                       clk,
  input  wire logic                       we_a,
  input  wire logic                       we_b,
  input  wire logic [mme_pkg::ADDR_W-1:0] waddr,
  input  wire mme_pkg::data_t             wdata,
  input  wire logic                       re,
  input  wire logic [mme_pkg::ADDR_W-1:0] raddr_a,
  input  wire logic [mme_pkg::ADDR_W-1:0] raddr_b,
  output mme_pkg::data_t                  rdata_a,
  output mme_pkg::data_t                  rdata_b
);
  import mme_pkg::*;

  data_t a_mem [DEPTH];
  data_t b_mem [DEPTH];

  // Loading and computing never overlap, so a read never meets a write
  // to the same entry and no bypass is needed.
  always_ff @(posedge clk) begin
    if (we_a) begin
      a_mem[waddr] <= wdata;
    end
    if (we_b) begin
      b_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= a_mem[raddr_a];
      rdata_b <= b_mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mme_mac.sv
// Multiply-accumulate pipeline with round-half-up and saturation of the sum.
// Depends on mme_pkg; operands come from the registered read port of mme_mem, in the cycle after the read.
`timescale 1ns / 1ps
`default_nettype none

module mme_mac (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mme_pkg::mme_issue_t issue,
  input  wire mme_pkg::data_t     rdata_a,
  input  wire mme_pkg::data_t     rdata_b,
  input  wire logic               take,
  output logic                    done,
  output mme_pkg::data_t          result
);
  import mme_pkg::*;

  localparam logic signed [ACC_W:0] HALF =
    (FRAC_BITS > 0) ? ((ACC_W+1)'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;
  localparam logic signed [ACC_W:0] MAXV = (ACC_W+1)'((2 ** (DATA_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W:0] MINV = -(ACC_W+1)'(2 ** (DATA_WIDTH - 1));

  mme_issue_t                s1_r, s2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      done_r;
  logic signed [ACC_W:0]     rounded;
  logic signed [ACC_W:0]     shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r <= issue;
      s2_r <= s1_r;
      if (s2_r.vld && s2_r.last) begin
        done_r <= 1'b1;
      end else if (take) begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_r.vld) begin
      prod_r <= rdata_a * rdata_b;
    end
    if (s2_r.vld) begin
      if (s2_r.first) begin
        acc_r <= ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  always_comb begin
    rounded = {acc_r[ACC_W-1], acc_r} + HALF;
    shifted = rounded >>> FRAC_BITS;
    if (shifted > MAXV) begin
      result = MAXV[DATA_WIDTH-1:0];
    end else if (shifted < MINV) begin
      result = MINV[DATA_WIDTH-1:0];
    end else begin
      result = shifted[DATA_WIDTH-1:0];
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

FILE: hdl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: load sequencer, result sequencer,
// output register. Depends on mme_pkg, mme_if, mme_regs, mme_mem and mme_mac.
`timescale 1ns / 1ps
`default_nettype none

// Elements stream in one per cycle, A row-major then B row-major, each
// written straight into its operand store; ready is high throughout loading.
// The request that carries the last element of B starts the computation,
// during which no element is taken. Each of the M*N results then passes
// through K reads of the two stores, feeding the single multiply-accumulate
// unit, then the multiplier, the accumulator and the hand-off to the output
// register; the hand-off waits while a full output register waits for the
// receiver. Results leave row-major through an output register; the last one
// is flagged, and loading of a new A resumes as soon as that last result
// sits in the output register. Dimensions of 0 act as 1 and values above 8
// act as 8. There is no clearing pass after reset.

module matrix_multiply_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mme_in_if.sink                           in_ch,
  mme_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mme_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mme_pkg::PDATA_W-1:0] pwdata,
  output logic      [mme_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import mme_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  mme_dims_t          dims;
  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt, j_r, j_nxt, l_r, l_nxt;

  logic [CNT_W-1:0]   asize, total, cnt_base, cnt_inc, b_off;
  logic               in_acc;
  logic               we_a, we_b;
  logic [ADDR_W-1:0]  waddr;

  logic [CNT_W-1:0]   a_lin, b_lin;
  logic               l_last, elem_last;
  mme_issue_t         issue;
  data_t              rdata_a, rdata_b, mac_result;
  logic               mac_done, take;

  logic               out_valid_r, out_valid_nxt;
  data_t              out_data_r;
  logic [IDX_W-1:0]   out_row_r, out_col_r;
  logic               out_last_r;

  mme_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  // Load side: a stale count at or beyond the current total restarts at A.
  always_comb begin
    asize    = CNT_W'(dims.m) * CNT_W'(dims.k);
    total    = asize + CNT_W'(dims.k) * CNT_W'(dims.n);
    cnt_base = (load_cnt_r >= total) ? '0 : load_cnt_r;
    cnt_inc  = cnt_base + CNT_W'(1);
    b_off    = cnt_base - asize;
    in_acc   = in_ch.valid && in_ch.ready;
    we_a     = in_acc && (cnt_base < asize);
    we_b     = in_acc && (cnt_base >= asize);
    waddr    = (cnt_base < asize) ? cnt_base[ADDR_W-1:0] : b_off[ADDR_W-1:0];
  end

  assign in_ch.ready = (state_r == ST_LOAD);

  // Compute side: one store read per cycle in ST_RUN; one result at a time.
  always_comb begin
    a_lin     = CNT_W'(i_r) * CNT_W'(dims.k) + CNT_W'(l_r);
    b_lin     = CNT_W'(l_r) * CNT_W'(dims.n) + CNT_W'(j_r);
    l_last    = (DIM_W'(l_r) == dims.k - DIM_W'(1));
    elem_last = (DIM_W'(i_r) == dims.m - DIM_W'(1)) &&
                (DIM_W'(j_r) == dims.n - DIM_W'(1));
    issue.vld   = (state_r == ST_RUN);
    issue.first = (l_r == '0);
    issue.last  = l_last;
    take        = (state_r == ST_WAIT) && mac_done && (!out_valid_r || out_ch.ready);
  end

  mme_mem u_mem (
    .clk     (clk),
    .we_a    (we_a),
    .we_b    (we_b),
    .waddr   (waddr),
    .wdata   (in_ch.element),
    .re      (issue.vld),
    .raddr_a (a_lin[ADDR_W-1:0]),
    .raddr_b (b_lin[ADDR_W-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mme_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (issue),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .take    (take),
    .done    (mac_done),
    .result  (mac_result)
  );

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    l_nxt        = l_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_inc == total) begin
            load_cnt_nxt = '0;
            i_nxt        = '0;
            j_nxt        = '0;
            l_nxt        = '0;
            state_nxt    = ST_RUN;
          end else begin
            load_cnt_nxt = cnt_inc;
          end
        end
      end
      ST_RUN: begin
        if (l_last) begin
          l_nxt     = '0;
          state_nxt = ST_WAIT;
        end else begin
          l_nxt = l_r + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (take) begin
          if (elem_last) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_RUN;
            if (DIM_W'(j_r) == dims.n - DIM_W'(1)) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      i_r        <= '0;
      j_r        <= '0;
      l_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      l_r        <= l_nxt;
    end
  end

  // Output register.
  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= mac_result;
      out_row_r  <= i_r;
      out_col_r  <= j_r;
      out_last_r <= elem_last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.product_element = out_data_r;
  assign out_ch.row_index       = out_row_r;
  assign out_ch.col_index       = out_col_r;
  assign out_ch.last_of_matrix  = out_last_r;

`ifndef SYNTHESIS
  // The stores are never written while they are being read.
  assert property (@(posedge clk) disable iff (!rst_n) !((we_a || we_b) && issue.vld))
    else $error("store write during compute read");

  // A finished sum never waits while new reads are still being issued.
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == ST_RUN) |-> !mac_done)
    else $error("accumulator overwritten before hand-off");

  // A result handed over lands in the output register in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) take |=> out_valid_r)
    else $error("result lost at hand-off");

  // The last element of a matrix returns the block to loading.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (take && elem_last) |=> (state_r == ST_LOAD && out_last_r))
    else $error("end of matrix not handled");
`endif

endmodule

`default_nettype wire
